>>> rtl/core/thac_pkg.sv
// ----------------------------------------------------------------------------
// thac_pkg
// shared types, codes and reset values of the tank heater and aerator
// controller
// ----------------------------------------------------------------------------
package thac_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned TempW  = 7;
  localparam int unsigned FracW  = 8;
  localparam int unsigned TickW  = 8;
  localparam int unsigned LevelW = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // event codes
  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SAMPLE = 3'd1,
    CMD_UP     = 3'd2,
    CMD_DOWN   = 3'd3,
    CMD_TOGGLE = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HYST_FRACTION    = 3'd0,
    CFG_TICKS_PER_PERIOD = 3'd1,
    CFG_TEMP_MIN_LIMIT   = 3'd2,
    CFG_TEMP_MAX_LIMIT   = 3'd3,
    CFG_AER_MAX_LEVEL    = 3'd4,
    CFG_AER_MIN_LEVEL    = 3'd5
  } cfg_idx_e;

  // reset values
  localparam logic [FracW-1:0]  RstHystFraction  = 8'd13;
  localparam logic [TickW-1:0]  RstTicksPerPer   = 8'd59;
  localparam logic [TempW-1:0]  RstTempMinLimit  = 7'd20;
  localparam logic [TempW-1:0]  RstTempMaxLimit  = 7'd60;
  localparam logic [LevelW-1:0] RstAerMaxLevel   = 4'd9;
  localparam logic [LevelW-1:0] RstAerMinLevel   = 4'd0;
  localparam logic [TempW-1:0]  RstSetpoint      = 7'd40;
  localparam logic [LevelW-1:0] RstLevel         = 4'd5;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TempW-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic              heater_on;
    logic              aerator_on;
    logic [TempW-1:0]  temp_setpoint;
    logic [LevelW-1:0] aer_level;
    logic              selected;
  } out_item_t;

endpackage

>>> rtl/core/thac_in_if.sv
// ----------------------------------------------------------------------------
// thac_in_if
// event channel: valid/ready handshake carrying command and temperature
// ----------------------------------------------------------------------------
interface thac_in_if;
  logic                          valid;
  logic                          ready;
  logic [thac_pkg::CmdW-1:0]     command;
  logic [thac_pkg::TempW-1:0]    temperature;

  modport source (output valid, output command, output temperature, input ready);
  modport sink   (input valid, input command, input temperature, output ready);
endinterface

>>> rtl/core/thac_out_if.sv
// ----------------------------------------------------------------------------
// thac_out_if
// result channel: valid/ready handshake carrying relay drives and settings
// ----------------------------------------------------------------------------
interface thac_out_if;
  logic                          valid;
  logic                          ready;
  logic                          heater_on;
  logic                          aerator_on;
  logic [thac_pkg::TempW-1:0]    temp_setpoint;
  logic [thac_pkg::LevelW-1:0]   aer_level;
  logic                          selected;

  modport source (output valid, output heater_on, output aerator_on,
                  output temp_setpoint, output aer_level, output selected,
                  input ready);
  modport sink   (input valid, input heater_on, input aerator_on,
                  input temp_setpoint, input aer_level, input selected,
                  output ready);
endinterface

>>> rtl/core/tank_heater_aerator_controller_top.sv
// ----------------------------------------------------------------------------
// tank_heater_aerator_controller_top
// hysteresis heater control and time-proportioned aeration driven by events
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries one event per transfer: tick, temperature sample, up, down
//   or select toggle. Every event produces exactly one result transfer on
//   out_ch showing relay drives and settings after the event.
//   Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i,
//   one register per cycle; only while no event is in flight, which the user must ensure.
// Flow and throughput
//   An accepted event waits in the input register, then the band
//   multiply, compares and counter updates run in a single pass and load
//   the result register, from which the result is offered on out_ch and
//   transfers at the edge where out_ch is ready.
//   One event per cycle is sustained while out_ch stays ready; the state
//   registers feed straight back into the next pass, so consecutive events need no gap.
// Reset
//   Asynchronous, active low: settings and counters return to their
//   defaults, both relays off, both channel stages empty.
// Stall
//   While out_ch is not ready the result register holds; the input register
//   then holds one more event and in_ch ready drops once both are full.
// ----------------------------------------------------------------------------
module tank_heater_aerator_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [thac_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [thac_pkg::CfgDataW-1:0]     cfg_data_i,
  thac_in_if.sink                           in_ch,
  thac_out_if.source                        out_ch
);

  localparam int unsigned TempW  = thac_pkg::TempW;
  localparam int unsigned FracW  = thac_pkg::FracW;
  localparam int unsigned TickW  = thac_pkg::TickW;
  localparam int unsigned LevelW = thac_pkg::LevelW;

  // configuration registers
  logic [FracW-1:0]  hyst_fraction_q;
  logic [TickW-1:0]  ticks_per_period_q;
  logic [TempW-1:0]  temp_min_limit_q;
  logic [TempW-1:0]  temp_max_limit_q;
  logic [LevelW-1:0] aer_max_level_q;
  logic [LevelW-1:0] aer_min_level_q;

  // controller state
  logic              heater_q, heater_d;
  logic              aerator_q, aerator_d;
  logic [TickW-1:0]  tick_count_q, tick_count_d;
  logic [LevelW-1:0] on_periods_q, on_periods_d;
  logic [LevelW-1:0] off_periods_q, off_periods_d;
  logic [TempW-1:0]  setpoint_q, setpoint_d;
  logic [LevelW-1:0] level_q, level_d;
  logic              select_q, select_d;

  // pipeline stages
  logic                 in_vld_q;
  thac_pkg::in_item_t   in_q;
  logic                 out_vld_q;
  thac_pkg::out_item_t  out_q;
  logic                 advance;

  // band arithmetic
  logic [TempW+FracW-1:0] band_prod;
  logic [TempW-1:0]       band;
  logic [TempW-1:0]       low_thresh;
  logic [TempW:0]         high_thresh;
  logic                   period_end;
  logic                   off_done;

  assign advance     = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_fraction_q    <= thac_pkg::RstHystFraction;
      ticks_per_period_q <= thac_pkg::RstTicksPerPer;
      temp_min_limit_q   <= thac_pkg::RstTempMinLimit;
      temp_max_limit_q   <= thac_pkg::RstTempMaxLimit;
      aer_max_level_q    <= thac_pkg::RstAerMaxLevel;
      aer_min_level_q    <= thac_pkg::RstAerMinLevel;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thac_pkg::CFG_HYST_FRACTION:    hyst_fraction_q    <= cfg_data_i;
        thac_pkg::CFG_TICKS_PER_PERIOD: ticks_per_period_q <= cfg_data_i;
        thac_pkg::CFG_TEMP_MIN_LIMIT:   temp_min_limit_q   <= cfg_data_i[TempW-1:0];
        thac_pkg::CFG_TEMP_MAX_LIMIT:   temp_max_limit_q   <= cfg_data_i[TempW-1:0];
        thac_pkg::CFG_AER_MAX_LEVEL:    aer_max_level_q    <= cfg_data_i[LevelW-1:0];
        thac_pkg::CFG_AER_MIN_LEVEL:    aer_min_level_q    <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q.command     <= in_ch.command;
      in_q.temperature <= in_ch.temperature;
    end
  end

  // hysteresis band: floor(setpoint * fraction / 256), never above setpoint
  assign band_prod   = {{FracW{1'b0}}, setpoint_q} * {{TempW{1'b0}}, hyst_fraction_q};
  assign band        = band_prod[TempW+FracW-1:FracW];
  assign low_thresh  = setpoint_q - band;
  assign high_thresh = {1'b0, setpoint_q} + {1'b0, band};

  assign period_end = (tick_count_q >= ticks_per_period_q);
  // off phase ends once off_periods reaches max - level; level above max ends it at once
  assign off_done   = (level_q > aer_max_level_q) ||
                      (off_periods_q >= (aer_max_level_q - level_q));

  // next state for the event in the input register
  always_comb begin
    heater_d      = heater_q;
    aerator_d     = aerator_q;
    tick_count_d  = tick_count_q;
    on_periods_d  = on_periods_q;
    off_periods_d = off_periods_q;
    setpoint_d    = setpoint_q;
    level_d       = level_q;
    select_d      = select_q;
    case (in_q.command)
      thac_pkg::CMD_TICK: begin
        if (!period_end) begin
          tick_count_d = tick_count_q + 1'b1;
        end else begin
          tick_count_d = '0;
          // aeration period step
          if (level_q == aer_max_level_q) begin
            if (!aerator_q) begin
              aerator_d = 1'b1; on_periods_d = LevelW'(1); off_periods_d = '0;
            end
          end else if (level_q == '0) begin
            if (aerator_q) begin
              aerator_d = 1'b0; on_periods_d = '0; off_periods_d = LevelW'(1);
            end
          end else if (aerator_q) begin
            if (on_periods_q >= level_q) begin
              aerator_d = 1'b0; on_periods_d = '0; off_periods_d = LevelW'(1);
            end else begin
              on_periods_d = on_periods_q + 1'b1;
            end
          end else begin
            if (off_done) begin
              aerator_d = 1'b1; on_periods_d = LevelW'(1); off_periods_d = '0;
            end else begin
              off_periods_d = off_periods_q + 1'b1;
            end
          end
        end
      end
      thac_pkg::CMD_SAMPLE: begin
        if (heater_q) begin
          if ({1'b0, in_q.temperature} >= high_thresh) heater_d = 1'b0;
        end else begin
          if (in_q.temperature < low_thresh) heater_d = 1'b1;
        end
      end
      thac_pkg::CMD_UP: begin
        if (!select_q) begin
          if (setpoint_q < temp_max_limit_q) setpoint_d = setpoint_q + 1'b1;
        end else begin
          if (level_q < aer_max_level_q) level_d = level_q + 1'b1;
        end
      end
      thac_pkg::CMD_DOWN: begin
        if (!select_q) begin
          if (setpoint_q > temp_min_limit_q) setpoint_d = setpoint_q - 1'b1;
        end else begin
          if (level_q > aer_min_level_q) level_d = level_q - 1'b1;
        end
      end
      thac_pkg::CMD_TOGGLE: begin
        select_d = !select_q;
      end
      default: ;
    endcase
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q      <= 1'b0;
      aerator_q     <= 1'b0;
      tick_count_q  <= '0;
      on_periods_q  <= '0;
      off_periods_q <= '0;
      setpoint_q    <= thac_pkg::RstSetpoint;
      level_q       <= thac_pkg::RstLevel;
      select_q      <= 1'b0;
    end else if (advance) begin
      heater_q      <= heater_d;
      aerator_q     <= aerator_d;
      tick_count_q  <= tick_count_d;
      on_periods_q  <= on_periods_d;
      off_periods_q <= off_periods_d;
      setpoint_q    <= setpoint_d;
      level_q       <= level_d;
      select_q      <= select_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.heater_on     <= heater_d;
      out_q.aerator_on    <= aerator_d;
      out_q.temp_setpoint <= setpoint_d;
      out_q.aer_level     <= level_d;
      out_q.selected      <= select_d;
    end
  end

  assign out_ch.valid         = out_vld_q;
  assign out_ch.heater_on     = out_q.heater_on;
  assign out_ch.aerator_on    = out_q.aerator_on;
  assign out_ch.temp_setpoint = out_q.temp_setpoint;
  assign out_ch.aer_level     = out_q.aer_level;
  assign out_ch.selected      = out_q.selected;

  // checks
  property p_state_holds_when_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      !advance |=> ($stable(heater_q) && $stable(aerator_q) && $stable(setpoint_q) &&
                    $stable(level_q) && $stable(select_q) && $stable(tick_count_q));
  endproperty
  a_state_holds_when_idle: assert property (p_state_holds_when_idle)
    else $error("state changed without an event being processed");

  a_heater_only_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (advance && (in_q.command != thac_pkg::CMD_SAMPLE)) |=> $stable(heater_q))
    else $error("heater changed on a non-sample event");

  a_result_follows_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
      advance |=> (out_vld_q && (out_q.heater_on == heater_q) &&
                   (out_q.temp_setpoint == setpoint_q) && (out_q.aer_level == level_q)))
    else $error("result register does not match state after event");

  a_forced_on_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (advance && (in_q.command == thac_pkg::CMD_TICK) && period_end &&
       (level_q == aer_max_level_q)) |=> aerator_q)
    else $error("aerator not on at maximum level after period step");

  a_no_event_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_vld_q && !advance) |=> in_vld_q)
    else $error("pending event dropped");

endmodule
